// File: design/fmp_pkg.sv
// Shared types and widths for the Fibonacci-remainder / Pisano-period block.
// Used by fmp_ctrl, fmp_datapath and fibonacci_mod_via_pisano_core.
package fmp_pkg;

  localparam int MOD_W     = 16;
  localparam int IDX_W     = 32;
  localparam int PER_W     = MOD_W + 3;
  localparam int IDX_CNT_W = $clog2(IDX_W);

  typedef struct packed {
    logic [MOD_W-1:0] modulus;
    logic [IDX_W-1:0] fib_index;
  } in_t;

  typedef struct packed {
    logic [MOD_W-1:0] fib_mod;
    logic [PER_W-1:0] period;
  } out_t;

  typedef struct packed {
    logic load;
    logic pair_step;
    logic cnt_inc;
    logic per_save;
    logic div_step;
    logic k_dec;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic trivial;
    logic period_found;
    logic div_last;
    logic k_zero;
  } status_t;

endpackage

// File: design/fibonacci_mod_via_pisano_core.sv
// Top level of the Fibonacci-remainder / Pisano-period block.
// Depends on fmp_pkg; instantiates fmp_ctrl and fmp_datapath.
//
//   channel   direction  handshake               payload
//   input     in         in_valid_i/in_stall_o   in_data_i  (modulus, fib_index)
//   output    out        out_valid_o/out_stall_i out_data_o (fib_mod, period)
//
// A transaction first steps the pair until it returns to (1, 0) or 6m steps are taken, giving
// the period P; then the remainder unit takes one index bit a cycle, and the pair is walked
// (n mod P) steps. Moduli 0 and 1 skip straight to the result.
// Reset clears only the controller state and the output valid flag.
// The next transaction is taken while a finished result waits in the output register.
module fibonacci_mod_via_pisano_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  fmp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output fmp_pkg::out_t out_data_o
);
  import fmp_pkg::*;

  cmd_t    cmd;
  status_t status;

  fmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fmp_datapath u_datapath (
    .clk_i      (clk_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

// File: design/fmp_datapath.sv
// Datapath: remainder pair, step counter, serial remainder unit and result register.
// Depends on fmp_pkg; driven by fmp_ctrl through cmd_t and status_t.
module fmp_datapath (
  input  logic            clk_i,
  input  fmp_pkg::in_t    in_data_i,
  input  fmp_pkg::cmd_t   cmd_i,
  output fmp_pkg::status_t status_o,
  output fmp_pkg::out_t   out_data_o
);
  import fmp_pkg::*;

  logic [MOD_W-1:0]     m_q, a_q, b_q;
  logic [MOD_W-1:0]     a_d, b_d;
  logic [IDX_W-1:0]     n_q;
  logic [PER_W-1:0]     cnt_q, limit_q, per_q, rem_q;
  logic [IDX_CNT_W-1:0] idx_q;
  out_t                 out_q;

  logic [MOD_W:0]   pair_sum;
  logic [PER_W:0]   rem_shift;
  logic [PER_W-1:0] rem_next;
  logic [PER_W-1:0] m_ext;
  out_t             out_d;

  // One step of the pair: (a, b) -> ((a + b) mod m, a).
  always_comb begin
    pair_sum = {1'b0, a_q} + {1'b0, b_q};
    if (pair_sum >= {1'b0, m_q}) begin
      pair_sum = pair_sum - {1'b0, m_q};
    end
    a_d = pair_sum[MOD_W-1:0];
    b_d = a_q;
  end

  // Restoring remainder step: one index bit per cycle, MSB first.
  always_comb begin
    rem_shift = {rem_q, n_q[IDX_W-1]};
    if (rem_shift >= {1'b0, per_q}) begin
      rem_shift = rem_shift - {1'b0, per_q};
    end
    rem_next = rem_shift[PER_W-1:0];
  end

  assign m_ext = {3'b000, in_data_i.modulus};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q     <= in_data_i.modulus;
      n_q     <= in_data_i.fib_index;
      limit_q <= (m_ext << 2) + (m_ext << 1);
      a_q     <= MOD_W'(1);
      b_q     <= '0;
      cnt_q   <= '0;
    end else if (cmd_i.per_save) begin
      per_q <= cnt_q;
      a_q   <= MOD_W'(1);
      b_q   <= '0;
      rem_q <= '0;
      idx_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_next;
      n_q   <= n_q << 1;
      idx_q <= idx_q + IDX_CNT_W'(1);
    end else if (cmd_i.pair_step) begin
      a_q <= a_d;
      b_q <= b_d;
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + PER_W'(1);
      end
      if (cmd_i.k_dec) begin
        rem_q <= rem_q - PER_W'(1);
      end
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    out_d.fib_mod = status_o.trivial ? '0 : b_q;
    if (m_q == '0) begin
      out_d.period = '0;
    end else if (status_o.trivial) begin
      out_d.period = PER_W'(1);
    end else begin
      out_d.period = per_q;
    end
  end

  assign status_o.trivial      = (m_q[MOD_W-1:1] == '0);
  assign status_o.period_found = (cnt_q != '0) &&
                                 (((a_q == MOD_W'(1)) && (b_q == '0)) || (cnt_q == limit_q));
  assign status_o.div_last     = (idx_q == IDX_CNT_W'(IDX_W - 1));
  assign status_o.k_zero       = (rem_q == '0);
  assign out_data_o            = out_q;

endmodule

// File: design/fmp_ctrl.sv
// Controller state machine: sequences period search, index reduction and walk.
// Depends on fmp_pkg; commands fmp_datapath and owns both handshakes.
module fmp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  fmp_pkg::status_t status_i,
  output fmp_pkg::cmd_t    cmd_o
);
  import fmp_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StPeriod = 3'd1;
  localparam logic [2:0] StDiv    = 3'd2;
  localparam logic [2:0] StWalk   = 3'd3;
  localparam logic [2:0] StDone   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StPeriod;
        end
      end
      StPeriod: begin
        if (status_i.trivial) begin
          state_d = StDone;
        end else if (status_i.period_found) begin
          cmd_o.per_save = 1'b1;
          state_d        = StDiv;
        end else begin
          cmd_o.pair_step = 1'b1;
          cmd_o.cnt_inc   = 1'b1;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StWalk;
        end
      end
      StWalk: begin
        if (status_i.k_zero) begin
          state_d = StDone;
        end else begin
          cmd_o.pair_step = 1'b1;
          cmd_o.k_dec     = 1'b1;
        end
      end
      StDone: begin
        // Wait until the result register is free or is being emptied.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_o.out_load)
    else $error("result register overwritten while stalled");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && in_valid_i) |=> (state_q == StPeriod))
    else $error("accepted transaction did not start period search");

  a_period_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPeriod && !status_i.trivial && status_i.period_found) |=> (state_q == StDiv))
    else $error("period found but reduction did not start");

  a_walk_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk && !status_i.k_zero) |=> (state_q == StWalk))
    else $error("walk ended before the reduced index reached zero");
`endif

endmodule

// File: verif/fibonacci_mod_via_pisano_checker.sv
`timescale 1ns / 1ps
// Checker for fibonacci_mod_via_pisano_core: watches both channels, predicts each result
// from the accepted input transaction and compares the two result fields in order.
// Depends on fmp_pkg for the payload types and widths.
module fibonacci_mod_via_pisano_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  fmp_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  fmp_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            due_count_o
);
  import fmp_pkg::*;

  // A zero modulus is refused; the block flags it with a period no real modulus has.
  localparam logic [PER_W-1:0] PERIOD_REJECTED = '0;
  localparam logic [PER_W-1:0] PERIOD_UNIT     = 1;

  typedef struct packed {
    in_t  item;
    out_t want;
  } fib_due_t;

  fib_due_t fib_results_due[$];
  fib_due_t head;
  int       errors;

  // One step of the remainder pair (a, b) -> ((a + b) mod m, a).
  function automatic void pair_advance(inout int unsigned a, inout int unsigned b,
                                       input int unsigned m);
    int unsigned sum;
    sum = a + b;
    if (sum >= m) begin
      sum = sum - m;
    end
    b = a;
    a = sum;
  endfunction

  function automatic out_t fib_mod_by_pisano(in_t item);
    int unsigned     m;
    int unsigned     a;
    int unsigned     b;
    int unsigned     per;
    longint unsigned steps_left;
    out_t            res;
    res = '0;
    m = 32'(item.modulus);
    if (m == 0) begin
      res.period = PERIOD_REJECTED;
    end else if (m == 1) begin
      res.period = PERIOD_UNIT;
    end else begin
      a = 1;
      b = 0;
      per = 0;
      do begin
        pair_advance(a, b, m);
        per++;
      end while (!(a == 1 && b == 0) && per < 6 * m);
      steps_left = longint'(item.fib_index) % per;
      a = 1;
      b = 0;
      while (steps_left != 0) begin
        pair_advance(a, b, m);
        steps_left--;
      end
      res.fib_mod = b[MOD_W-1:0];
      res.period  = per[PER_W-1:0];
    end
    return res;
  endfunction

  // Counts are published with nonblocking updates so the stimulus side sees
  // settled values from the next edge on, independent of process order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fib_results_due.delete();
      errors = 0;
      fail_count_o <= 0;
      due_count_o  <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        head.item = in_data_i;
        head.want = fib_mod_by_pisano(in_data_i);
        fib_results_due.push_back(head);
      end
      if (out_valid_i && !out_stall_i) begin
        if (fib_results_due.size() == 0) begin
          errors++;
          $display("%0t: result transaction with none expected: fib_mod=%0d period=%0d",
                   $time, out_data_i.fib_mod, out_data_i.period);
        end else begin
          head = fib_results_due.pop_front();
          if (out_data_i.fib_mod !== head.want.fib_mod) begin
            errors++;
            $display("%0t: fib_mod mismatch for m=%0d n=%0d: expected %0d, got %0d",
                     $time, head.item.modulus, head.item.fib_index,
                     head.want.fib_mod, out_data_i.fib_mod);
          end
          if (out_data_i.period !== head.want.period) begin
            errors++;
            $display("%0t: period mismatch for m=%0d n=%0d: expected %0d, got %0d",
                     $time, head.item.modulus, head.item.fib_index,
                     head.want.period, out_data_i.period);
          end
        end
      end
      fail_count_o <= errors;
      due_count_o  <= fib_results_due.size();
    end
  end

endmodule

// File: verif/tb_fibonacci_mod_via_pisano_core.sv
`timescale 1ns / 1ps
// Testbench top for fibonacci_mod_via_pisano_core: drives directed and random
// transactions with random idling and back-pressure, and gives the verdict.
// Depends on fmp_pkg, the core, and fibonacci_mod_via_pisano_checker.
module tb_fibonacci_mod_via_pisano_core;
  import fmp_pkg::*;

  localparam int     RX_HOLD_CYCLES = 1500;
  localparam int     SETTLE_CYCLES  = 64;
  localparam int     RANDOM_ITEMS   = 70;
  localparam longint RUN_LIMIT_NS   = 64'd4_000_000_000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  int   fail_count;
  int   due_count;
  int   hold_req = 0;
  bit   rx_quiet = 1'b1;

  always #5 clk = ~clk;

  fibonacci_mod_via_pisano_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  fibonacci_mod_via_pisano_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .due_count_o (due_count)
  );

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  // Small moduli dominate since the core's run time grows with the modulus.
  function automatic logic [MOD_W-1:0] random_modulus();
    int roll;
    roll = $urandom_range(1, 100);
    if (roll <= 6) begin
      return MOD_W'($urandom_range(0, 1));
    end else if (roll <= 80) begin
      return MOD_W'($urandom_range(2, 300));
    end else if (roll <= 97) begin
      return MOD_W'($urandom_range(301, 3000));
    end
    return MOD_W'($urandom_range(3001, 65535));
  endfunction

  function automatic logic [IDX_W-1:0] random_index();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      2, 3: return $urandom_range(0, 64);
      default: return $urandom();
    endcase
  endfunction

  task automatic offer_item(input logic [MOD_W-1:0] m, input logic [IDX_W-1:0] n,
                            input bit may_idle);
    in_t pkt;
    int  gap;
    pkt.modulus   = m;
    pkt.fib_index = n;
    in_data  <= pkt;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    gap = may_idle ? pick_idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The due count is registered behind the channels, hence the leading wait.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
  endtask

  // Receiver: random stall runs, quiet stretches, and one long hold-off on request.
  initial begin : receiver
    int stall_left;
    int hold_seen;
    stall_left = 0;
    hold_seen  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        stall_left = 0;
        out_stall <= 1'b0;
      end else if (rx_quiet) begin
        stall_left = 0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 2) == 0) begin
          stall_left = pick_idle_len();
        end
      end
    end
  end

  initial begin : stimulus
    bit quiet;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: rejected and unit moduli, index extremes, the largest modulus,
    // an index equal to the period, and alternating bit patterns.
    offer_item(16'd0, 32'd0, 1'b0);
    offer_item(16'd0, 32'hFFFF_FFFF, 1'b0);
    offer_item(16'd1, 32'd0, 1'b0);
    offer_item(16'd1, 32'hFFFF_FFFF, 1'b0);
    offer_item(16'd1, 32'd12345, 1'b0);
    offer_item(16'd2, 32'd0, 1'b0);
    offer_item(16'd2, 32'd1, 1'b0);
    offer_item(16'd2, 32'd2, 1'b0);
    offer_item(16'd2, 32'd3, 1'b0);
    offer_item(16'd2, 32'hFFFF_FFFF, 1'b0);
    offer_item(16'd3, 32'd7, 1'b0);
    offer_item(16'd10, 32'd10, 1'b0);
    offer_item(16'd10, 32'd60, 1'b0);
    offer_item(16'd7, 32'd16, 1'b0);
    offer_item(16'd5, 32'd19, 1'b0);
    offer_item(16'd144, 32'd12, 1'b0);
    offer_item(16'd1000, 32'h8000_0000, 1'b0);
    offer_item(16'd65535, 32'd0, 1'b0);
    offer_item(16'd65535, 32'hFFFF_FFFF, 1'b0);
    offer_item(16'd65535, 32'd15479, 1'b0);
    offer_item(16'd65534, 32'h5555_5555, 1'b0);
    offer_item(16'd21845, 32'hAAAA_AAAA, 1'b0);

    // The sender stays quiet until every outstanding result has drained.
    wait_all_results();

    // Long receiver hold-off while the sender keeps offering quick transactions,
    // so the output register fills and the core stalls its input.
    rx_quiet = 1'b0;
    hold_req++;
    for (int i = 0; i < 10; i++) begin
      offer_item(MOD_W'($urandom_range(0, 12)), random_index(), 1'b0);
    end
    wait_all_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet    = (i >= 40 && i < 55);
      rx_quiet = quiet;
      offer_item(random_modulus(), random_index(), !quiet);
    end
    rx_quiet = 1'b0;

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("fibonacci_mod_via_pisano_core regression: pass");
    end else begin
      $display("fibonacci_mod_via_pisano_core regression: fail");
    end
    $finish;
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("fibonacci_mod_via_pisano_core regression: fail");
    $finish;
  end

endmodule
